>>> hdl/mf3_pkg.sv
// ============================================================================
// mf3_pkg: shared definitions for the 3x3 median filter
// Field widths, register indexes, reset values and the small compare
// functions that build the median network.
// ============================================================================
package mf3_pkg;

    localparam int PIX_W             = 8;
    localparam int ROW_W             = 12;
    localparam int OUT_COL_W         = 10;
    localparam int IMG_W_W           = 11;
    localparam int IMG_H_W           = 13;
    localparam int CFG_DATA_W        = 13;
    localparam int CFG_IDX_W         = 1;
    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int RESET_WIDTH       = 1024;
    localparam int RESET_HEIGHT      = 1024;
    localparam int MAX_HEIGHT        = 4096;
    localparam int MIN_DIM           = 3;

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // One window column with its three pixels in ascending order.
    typedef struct packed {
        pix_t hi;
        pix_t me;
        pix_t lo;
    } col_t;

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
        col_t r;
        r.lo = min3(a, b, c);
        r.me = med3(a, b, c);
        r.hi = max3(a, b, c);
        return r;
    endfunction

endpackage

>>> hdl/median_filter_3x3_unit.sv
// Pipeline: the pixel completing a window passes through the input stage, the
// reduction stage and then the output register before its result appears on
// the output.
// Throughput: one pixel per clock while out_ready does not stall the output;
// each line store is read and written once per pixel, which sets that rate.
// Border pixels produce no result. Reset: counters, valid flags and configuration
// registers return to their defaults at once; line stores and data registers are not cleared.
// ============================================================================
// median_filter_3x3_unit: streaming 3x3 median filter
// Two line stores and a window of pre-sorted columns feed a median network
// split over two register stages.
// ============================================================================
module median_filter_3x3_unit #(
    parameter int MAX_WIDTH = mf3_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mf3_pkg::PIX_W-1:0]      pixel_value,
    input  logic                           frame_start,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mf3_pkg::PIX_W-1:0]      median_value,
    output logic [mf3_pkg::ROW_W-1:0]      out_row,
    output logic [mf3_pkg::OUT_COL_W-1:0]  out_col,
    output logic                           frame_last
);
    import mf3_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WCMP_W  = (IMG_W_W > $clog2(MAX_WIDTH + 1)) ? IMG_W_W
                                                                : $clog2(MAX_WIDTH + 1);
    localparam logic [WCMP_W-1:0]  W_MIN = WCMP_W'(MIN_DIM);
    localparam logic [WCMP_W-1:0]  W_MAX = WCMP_W'(MAX_WIDTH);
    localparam logic [IMG_H_W-1:0] H_MIN = IMG_H_W'(MIN_DIM);
    localparam logic [IMG_H_W-1:0] H_MAX = IMG_H_W'(MAX_HEIGHT);

    // Configuration
    logic [IMG_W_W-1:0] image_width_reg;
    logic [IMG_H_W-1:0] image_height_reg;
    logic [WCMP_W-1:0]  width_ext;
    logic [WCMP_W-1:0]  width_clamped;
    logic [IMG_H_W-1:0] height_clamped;
    logic [COL_W-1:0]   width_m1;
    logic [ROW_W-1:0]   height_m1;

    // Position counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             col_end;
    logic             row_end;
    logic             cur_emit;
    logic             cur_last;

    // Line stores
    pix_t upper_mem  [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];
    pix_t up_rd_reg;
    pix_t mid_rd_reg;

    // Input stage
    logic             s1_valid_reg;
    pix_t             s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic             byp_reg;
    pix_t             byp_up_reg;
    pix_t             byp_mid_reg;
    pix_t             s1_up;
    pix_t             s1_mid;
    logic             hit;
    col_t             cur_sorted;
    col_t             win0_reg;
    col_t             win1_reg;

    // Reduction stage
    logic                 s2_valid_reg;
    pix_t                 s2_lo_reg;
    pix_t                 s2_me_reg;
    pix_t                 s2_hi_reg;
    logic [ROW_W-1:0]     s2_row_reg;
    logic [OUT_COL_W-1:0] s2_col_reg;
    logic                 s2_last_reg;

    // Output stage
    logic                 out_valid_reg;
    pix_t                 median_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic                 frame_last_reg;

    logic out_adv;
    logic s2_en;
    logic s1_en;
    logic accept;

    assign out_adv = !out_valid_reg || out_ready;
    assign s2_en   = !s2_valid_reg || out_adv;
    assign s1_en   = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;
    assign accept  = in_valid && s1_en;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMG_W_W'(RESET_WIDTH);
            image_height_reg <= IMG_H_W'(RESET_HEIGHT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_H_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        width_ext = WCMP_W'(image_width_reg);
        if (width_ext < W_MIN)
            width_clamped = W_MIN;
        else if (width_ext > W_MAX)
            width_clamped = W_MAX;
        else
            width_clamped = width_ext;

        if (image_height_reg < H_MIN)
            height_clamped = H_MIN;
        else if (image_height_reg > H_MAX)
            height_clamped = H_MAX;
        else
            height_clamped = image_height_reg;

        width_m1  = COL_W'(width_clamped - WCMP_W'(1));
        height_m1 = ROW_W'(height_clamped - IMG_H_W'(1));
    end

    // ------------------------------------------------------------------------
    // Raster position
    // ------------------------------------------------------------------------
    assign cur_col  = frame_start ? '0 : col_reg;
    assign cur_row  = frame_start ? '0 : row_reg;
    assign col_end  = cur_col >= width_m1;
    assign row_end  = cur_row >= height_m1;
    assign cur_emit = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
    assign cur_last = col_end && row_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : cur_row + ROW_W'(1);
            end
            else
            begin
                col_reg <= cur_col + COL_W'(1);
                row_reg <= cur_row;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Line stores. A column is read when its pixel is accepted and rewritten
    // when that pixel leaves the input stage. Two back-to-back transactions
    // at the same column (a repeated frame start) take the pending data from
    // the input stage instead of the store.
    // ------------------------------------------------------------------------
    assign hit    = s1_valid_reg && (s1_col_reg == cur_col);
    assign s1_up  = byp_reg ? byp_up_reg  : up_rd_reg;
    assign s1_mid = byp_reg ? byp_mid_reg : mid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg  <= upper_mem[cur_col];
            mid_rd_reg <= middle_mem[cur_col];
        end
        if (s1_en && s1_valid_reg)
        begin
            upper_mem[s1_col_reg]  <= s1_mid;
            middle_mem[s1_col_reg] <= s1_pixel_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Input stage
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel_value;
            s1_col_reg   <= cur_col;
            s1_row_reg   <= cur_row;
            s1_emit_reg  <= cur_emit;
            s1_last_reg  <= cur_last;
            byp_reg      <= hit;
            byp_up_reg   <= s1_mid;
            byp_mid_reg  <= s1_pixel_reg;
        end
    end

    // The window keeps each column already sorted, so only the newest column
    // needs sorting before the row-wise reduction.
    assign cur_sorted = sort3(s1_up, s1_mid, s1_pixel_reg);

    always_ff @(posedge clk)
    begin
        if (s1_en && s1_valid_reg)
        begin
            win0_reg <= win1_reg;
            win1_reg <= cur_sorted;
        end
    end

    // ------------------------------------------------------------------------
    // Reduction stage: largest low, middle median and smallest high.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_en)
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg && s1_emit_reg)
        begin
            s2_lo_reg   <= max3(win0_reg.lo, win1_reg.lo, cur_sorted.lo);
            s2_me_reg   <= med3(win0_reg.me, win1_reg.me, cur_sorted.me);
            s2_hi_reg   <= min3(win0_reg.hi, win1_reg.hi, cur_sorted.hi);
            s2_row_reg  <= s1_row_reg - ROW_W'(1);
            s2_col_reg  <= OUT_COL_W'(s1_col_reg - COL_W'(1));
            s2_last_reg <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s2_valid_reg)
        begin
            median_reg     <= med3(s2_lo_reg, s2_me_reg, s2_hi_reg);
            out_row_reg    <= s2_row_reg;
            out_col_reg    <= s2_col_reg;
            frame_last_reg <= s2_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_value = median_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign frame_last   = frame_last_reg;

endmodule

>>> hdl/mf3_checker.sv
// ============================================================================
// mf3_checker: port-level checks for the 3x3 median filter
// Watches the handshakes and result coordinates of the top level.
// ============================================================================
module mf3_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [mf3_pkg::PIX_W-1:0]      median_value,
    input logic [mf3_pkg::ROW_W-1:0]      out_row,
    input logic [mf3_pkg::OUT_COL_W-1:0]  out_col,
    input logic                           frame_last
);
    import mf3_pkg::*;

    localparam logic [ROW_W-1:0] ROW_ALL_ONES = '1;

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median_value)
            && $stable(out_row) && $stable(out_col) && $stable(frame_last))
    else $error("result changed while stalled");

    // With the output empty the whole pipeline can move, so input is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input refused while output register empty");

    // Results only come from interior rows.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_row != '0) && (out_row != ROW_ALL_ONES))
    else $error("result row outside the interior");

    // No result may be present as reset is released.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
    else $error("result present straight after reset");

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (.*);
